FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the scheduler.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/srt_pkg.sv
// Package of the shortest-remaining-time scheduler: widths, payload structs,
// and the structs that pass between the control logic and the cell chain.
`default_nettype none

package srt_pkg;

  localparam int FIELD_W          = 12;
  localparam int TIME_W           = 17;
  localparam int INDEX_W          = 4;
  localparam int MAX_PROC_DEFAULT = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [FIELD_W-1:0] arrival_time;
    logic [FIELD_W-1:0] service_time;
    logic               last_process;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] process_index;
    logic [TIME_W-1:0]  finish_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  wait_time;
    logic               last_result;
  } out_t;

  // Search record that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic               have_sel;
    logic [FIELD_W-1:0] sel_rem;
    logic               have_next;
    logic [FIELD_W-1:0] next_arr;
    logic               run_ok;
    logic [FIELD_W-1:0] run_rem;
  } wave_t;

  // Write command broadcast to every cell; the addressed cell takes it.
  typedef struct packed {
    logic               load;
    logic               update;
    logic               finish;
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] svc;
    logic [FIELD_W-1:0] rem;
    logic [TIME_W-1:0]  fin;
  } cell_ctl_t;

  typedef struct packed {
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] svc;
    logic [TIME_W-1:0]  fin;
  } cell_data_t;

endpackage

`default_nettype wire

FILE: hdl/srt_cell.sv
// One process slot of the scheduler's cell chain.
// Depends on srt_pkg; instantiated by shortest_remaining_time_scheduler.
`default_nettype none

module srt_cell
  import srt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  wire logic            clk,
  input  wire cell_ctl_t       ctl,
  input  wire logic [IW-1:0]   wr_idx,
  input  wire logic [TIME_W-1:0] tick,
  input  wire logic [IW-1:0]   run_idx,
  input  wire logic [CW-1:0]   count,
  input  wire wave_t           wave_in,
  input  wire logic [IW-1:0]   wave_idx_in,
  output wave_t                wave_out,
  output logic [IW-1:0]        wave_idx_out,
  output cell_data_t           data
);

  logic [FIELD_W-1:0] arr;
  logic [FIELD_W-1:0] svc;
  logic [FIELD_W-1:0] rem;
  logic [TIME_W-1:0]  fin;
  logic               hit;
  logic               pending;
  logic               arrived;
  wave_t              wave_next;
  logic [IW-1:0]      wave_idx_next;

  assign hit     = (wr_idx == IW'(IDX));
  assign pending = (CW'(IDX) < count) && (rem != '0);
  assign arrived = (TIME_W'(arr) <= tick);

  always_ff @(posedge clk) begin
    if (ctl.load && hit) begin
      arr <= ctl.arr;
      svc <= ctl.svc;
      rem <= ctl.svc;
      fin <= TIME_W'(ctl.arr);
    end else if (ctl.update && hit) begin
      rem <= ctl.rem;
      if (ctl.finish) begin
        fin <= ctl.fin;
      end
    end
  end

  // Fold this slot into the record: least remaining among arrived slots
  // (earlier slot wins a tie), and earliest arrival among those still to come.
  always_comb begin
    wave_next     = wave_in;
    wave_idx_next = wave_idx_in;
    if (pending && arrived) begin
      if (!wave_in.have_sel || rem < wave_in.sel_rem) begin
        wave_next.have_sel = 1'b1;
        wave_next.sel_rem  = rem;
        wave_idx_next      = IW'(IDX);
      end
      if (run_idx == IW'(IDX)) begin
        wave_next.run_ok  = 1'b1;
        wave_next.run_rem = rem;
      end
    end else if (pending) begin
      if (!wave_in.have_next || arr < wave_in.next_arr) begin
        wave_next.have_next = 1'b1;
        wave_next.next_arr  = arr;
      end
    end
  end

  always_ff @(posedge clk) begin
    wave_out     <= wave_next;
    wave_idx_out <= wave_idx_next;
  end

  assign data = '{arr: arr, svc: svc, fin: fin};

endmodule

`default_nettype wire

FILE: hdl/shortest_remaining_time_scheduler.sv
// Shortest-remaining-time-first scheduler, top level.
// Depends on srt_pkg, srt_cell and assert_macros.svh.
//
// Usage. Processes arrive on the input channel (in_valid / in_ready), one
// transaction per process carrying its arrival and service time, and are
// stored in load order; in_ready holds high throughout loading. The
// transaction with last_process set, or the one that fills all
// MAX_PROCESSES slots, starts a preemptive schedule from tick 0; no input is
// taken until every result of the set has been delivered.
// The schedule jumps from event to event (a completion, an arrival, or the
// end of an idle gap). For each event a search record walks the chain of
// cells, one cell per cycle, in the sweep state, and the step state then
// applies the chosen run. A set of N processes has at most about 2N events.
// Results then leave on the output channel (out_valid / out_ready), one
// transaction per process in index order, each passing through the read,
// calculate and send states; a stalled receiver simply holds the current
// result in the output register until it is taken.
// Synchronous reset empties the set, clears start_offset and returns the
// block to loading. start_offset may be written through cfg_wr_en at any
// time the block is idle.
`default_nettype none
`include "assert_macros.svh"

module shortest_remaining_time_scheduler
  import srt_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROC_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data
);

  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_SWEEP = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_RD    = 6'b001000,
    ST_CALC  = 6'b010000,
    ST_SEND  = 6'b100000
  } state_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W+1:0] v);
    logic [TIME_W-1:0] r;
    r = (v > (TIME_W+2)'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
    return r;
  endfunction

  state_t               state;
  logic [CW-1:0]        loaded_count;
  logic [CW-1:0]        left;
  logic [IW-1:0]        sweep_cnt;
  logic [TIME_W-1:0]    tick;
  logic [IW-1:0]        run_idx;
  logic [IW-1:0]        out_idx;
  logic [FIELD_W-1:0]   start_offset;
  logic [TIME_W:0]      fin_r;
  logic [FIELD_W-1:0]   arr_r;
  logic signed [FIELD_W:0] dos_r;

  // Cell chain wiring: the record enters the first cell empty.
  wave_t                wave     [MAX_PROCESSES+1];
  logic [IW-1:0]        wave_idx [MAX_PROCESSES+1];
  cell_data_t           cdata    [MAX_PROCESSES];
  cell_ctl_t            ctl;
  logic [IW-1:0]        wr_idx;

  // Decision signals of the step cycle.
  wave_t                w;
  logic [IW-1:0]        sel_idx;
  logic [FIELD_W-1:0]   gap;
  logic [FIELD_W-1:0]   run_len;
  logic [FIELD_W-1:0]   rem_new;
  logic [TIME_W-1:0]    tick_new;
  logic [CW-1:0]        left_inc;
  logic                 load_last;
  cell_data_t           rd_data;
  logic [TIME_W:0]      tat;
  logic [TIME_W+1:0]    wt_sum;

  assign wave[0]     = '0;
  assign wave_idx[0] = '0;

  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    srt_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .wr_idx       (wr_idx),
      .tick         (tick),
      .run_idx      (run_idx),
      .count        (loaded_count),
      .wave_in      (wave[i]),
      .wave_idx_in  (wave_idx[i]),
      .wave_out     (wave[i+1]),
      .wave_idx_out (wave_idx[i+1]),
      .data         (cdata[i])
    );
  end

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_SEND);

  // The record at the end of the chain holds the lowest-index minimum. The
  // process that ran last keeps the slot when its remaining time ties.
  // A run lasts until the chosen process completes or the next arrival.
  assign w        = wave[MAX_PROCESSES];
  assign sel_idx  = (w.run_ok && (w.run_rem == w.sel_rem)) ? run_idx
                                                           : wave_idx[MAX_PROCESSES];
  assign gap      = w.next_arr - tick[FIELD_W-1:0];
  assign run_len  = (w.have_next && (gap < w.sel_rem)) ? gap : w.sel_rem;
  assign rem_new  = w.sel_rem - run_len;
  assign tick_new = sat_time((TIME_W+2)'(tick) + (TIME_W+2)'(run_len));

  assign left_inc  = left + CW'(in_data.service_time != '0);
  assign load_last = in_data.last_process || (loaded_count == CW'(MAX_PROCESSES - 1));

  always_comb begin
    ctl        = '0;
    ctl.arr    = in_data.arrival_time;
    ctl.svc    = in_data.service_time;
    ctl.rem    = rem_new;
    ctl.fin    = tick_new;
    ctl.finish = (rem_new == '0);
    ctl.load   = (state == ST_LOAD) && in_valid;
    ctl.update = (state == ST_STEP) && w.have_sel;
    wr_idx     = (state == ST_LOAD) ? loaded_count[IW-1:0] : sel_idx;
  end

  assign rd_data = cdata[out_idx];
  assign tat     = fin_r - (TIME_W+1)'(arr_r);
  assign wt_sum  = (TIME_W+2)'(tat) + (TIME_W+2)'(dos_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
    end else if (cfg_wr_en) begin
      start_offset <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      loaded_count <= '0;
      left         <= '0;
      sweep_cnt    <= '0;
      tick         <= '0;
      run_idx      <= '0;
      out_idx      <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            loaded_count <= loaded_count + CW'(1);
            left         <= left_inc;
            if (load_last) begin
              tick      <= '0;
              run_idx   <= '0;
              sweep_cnt <= '0;
              out_idx   <= '0;
              state     <= (left_inc == '0) ? ST_RD : ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + IW'(1);
          if (sweep_cnt == IW'(MAX_PROCESSES - 1)) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          sweep_cnt <= '0;
          state     <= ST_SWEEP;
          if (!w.have_sel) begin
            // Nothing ready: skip the idle gap to the next arrival.
            tick <= TIME_W'(w.next_arr);
          end else begin
            run_idx <= sel_idx;
            tick    <= tick_new;
            if (rem_new == '0) begin
              left <= left - CW'(1);
              if (left == CW'(1)) begin
                state <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (out_ready) begin
            if (out_data.last_result) begin
              loaded_count <= '0;
              left         <= '0;
              state        <= ST_LOAD;
            end else begin
              out_idx <= out_idx + IW'(1);
              state   <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result datapath: read the slot, then form the three times.
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      fin_r <= (TIME_W+1)'(rd_data.fin) + (TIME_W+1)'(start_offset);
      arr_r <= rd_data.arr;
      dos_r <= $signed({1'b0, start_offset}) - $signed({1'b0, rd_data.svc});
    end
    if (state == ST_CALC) begin
      out_data.process_index   <= INDEX_W'(out_idx);
      out_data.finish_time     <= sat_time((TIME_W+2)'(fin_r));
      out_data.turnaround_time <= sat_time((TIME_W+2)'(tat));
      out_data.wait_time       <= sat_time(wt_sum);
      out_data.last_result     <= (CW'(out_idx) == (loaded_count - CW'(1)));
    end
  end

  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!out_valid && in_ready), "outputs not quiet after reset")
  `ASSERT_CLK(a_one_side, clk, rst, !(in_ready && out_valid), "loading while results are pending")
  `ASSERT_CLK(a_left_bound, clk, rst, (left <= loaded_count), "more unfinished processes than loaded")
  `ASSERT_CLK(a_step_work, clk, rst, (state == ST_STEP) |-> (w.have_sel || w.have_next), "schedule step with no process to run or await")
  `ASSERT_CLK(a_last_back, clk, rst, (out_valid && out_ready && out_data.last_result) |=> in_ready, "block did not return to loading after the final result")

endmodule

`default_nettype wire

FILE: sim/tb_shortest_remaining_time_scheduler.sv
`timescale 1ns / 100ps
// Self-checking testbench for the shortest-remaining-time-first scheduler.
// Depends on srt_pkg and the shortest_remaining_time_scheduler RTL; needs no files.

module tb_shortest_remaining_time_scheduler;
  import srt_pkg::*;

  localparam int SLOTS          = 16;
  // Quiet cycles allowed before the run is declared hung. The slowest set has
  // sixteen processes and at most 32 events, then sixteen results under
  // receiver stalls.
  localparam int WATCHDOG_LIMIT = 20000;
  // Cycles left after the last result before the block is treated as idle.
  localparam int SETTLE_CYCLES  = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_wr_en = 1'b0;
  logic [FIELD_W-1:0]  cfg_wr_data = '0;

  shortest_remaining_time_scheduler #(
    .MAX_PROCESSES(SLOTS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the scheduler state: the processes of the set being
  // loaded, their finish ticks once scheduled, and the offset register.
  logic [FIELD_W-1:0] set_arrival [SLOTS];
  logic [FIELD_W-1:0] set_service [SLOTS];
  int unsigned        set_finish  [SLOTS];
  int unsigned        set_count = 0;
  logic [FIELD_W-1:0] offset_shadow = '0;

  // Results still owed by the block, oldest first.
  out_t expected_reports [$];

  // Idling controls. When calm is set, no new random gaps or stalls are drawn.
  bit          calm = 1'b0;
  int unsigned in_gap_pct = 25;
  int unsigned out_stall_pct = 25;
  int unsigned stall_left = 0;

  int unsigned mismatches = 0;
  int unsigned reports_checked = 0;
  int unsigned loads_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned offsets_written = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [TIME_W-1:0] clamp_time(int unsigned v);
    return (v > TIME_MAX) ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  // Runs the preemptive schedule of the loaded set from tick 0 and queues
  // the report for every process in load order. The simulation jumps from
  // event to event: a process runs until it completes or until the next
  // arrival, whichever comes first, and an empty ready set skips straight to
  // the next arrival. On equal remaining time the process that ran last
  // keeps the processor; otherwise the lowest index wins.
  function automatic void schedule_loaded_set();
    int unsigned remaining [SLOTS];
    int unsigned tick;
    int unsigned unfinished;
    int unsigned chosen;
    int unsigned incumbent;
    int unsigned next_arrival;
    int unsigned burst;
    int unsigned fin;
    int unsigned turnaround;
    int unsigned waited;
    bit          found;
    bit          pending_arrival;
    out_t        report;

    tick = 0;
    unfinished = 0;
    incumbent = 0;
    for (int i = 0; i < set_count; i++) begin
      remaining[i] = set_service[i];
      if (set_service[i] == 0) begin
        set_finish[i] = set_arrival[i];
      end else begin
        unfinished++;
      end
    end

    while (unfinished > 0) begin
      found = 1'b0;
      pending_arrival = 1'b0;
      chosen = 0;
      next_arrival = 0;
      for (int i = 0; i < set_count; i++) begin
        if (remaining[i] != 0) begin
          if (set_arrival[i] <= tick) begin
            if (!found || remaining[i] < remaining[chosen]) begin
              chosen = i;
              found = 1'b1;
            end
          end else if (!pending_arrival || set_arrival[i] < next_arrival) begin
            next_arrival = set_arrival[i];
            pending_arrival = 1'b1;
          end
        end
      end

      if (!found) begin
        tick = next_arrival;
      end else begin
        if (incumbent < set_count && incumbent != chosen &&
            remaining[incumbent] != 0 && set_arrival[incumbent] <= tick &&
            remaining[incumbent] == remaining[chosen]) begin
          chosen = incumbent;
        end
        burst = remaining[chosen];
        if (pending_arrival && next_arrival - tick < burst) begin
          burst = next_arrival - tick;
        end
        remaining[chosen] -= burst;
        tick += burst;
        incumbent = chosen;
        if (remaining[chosen] == 0) begin
          set_finish[chosen] = clamp_time(tick);
          unfinished--;
        end
      end
    end

    for (int i = 0; i < set_count; i++) begin
      fin        = set_finish[i] + offset_shadow;
      turnaround = fin - set_arrival[i];
      waited     = turnaround - set_service[i] + offset_shadow;
      report.process_index   = i[INDEX_W-1:0];
      report.finish_time     = clamp_time(fin);
      report.turnaround_time = clamp_time(turnaround);
      report.wait_time       = clamp_time(waited);
      report.last_result     = (i + 1 == set_count);
      expected_reports.push_back(report);
    end
    set_count = 0;
    sets_sent++;
  endfunction

  // Offers one process to the block, with an optional idle burst first, and
  // holds the transaction until the block takes it. Valid is left high so
  // that a following transaction can go out back to back.
  task automatic send_process(input int unsigned arrival, input int unsigned service,
                              input bit last_flag);
    in_t item;
    item.arrival_time = arrival[FIELD_W-1:0];
    item.service_time = service[FIELD_W-1:0];
    item.last_process = last_flag;
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    loads_sent++;
    set_arrival[set_count] = item.arrival_time;
    set_service[set_count] = item.service_time;
    set_count++;
    if (item.last_process || set_count == SLOTS) begin
      schedule_loaded_set();
    end
  endtask

  // Holds the sender back until every owed result has been delivered.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // The register is only written once the block has delivered everything
  // and has had time to settle back into loading.
  task automatic set_start_offset(input int unsigned value);
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[FIELD_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    offset_shadow = value[FIELD_W-1:0];
    offsets_written++;
  endtask

  // Single-process sets at both ends of the field ranges. The second one
  // also leaves a long idle gap before its only process arrives.
  task automatic test_lone_processes();
    set_start_offset(0);
    send_process(0, 1, 1'b1);
    send_process(4095, 4095, 1'b1);
  endtask

  // One hand-built set that walks through the scheduling rules: a tie in
  // which the running process keeps the slot, an idle gap, a zero-length
  // process, a preemption by a shorter arrival, and a tie between two
  // fresh arrivals that the lower index wins.
  task automatic test_scheduling_rules();
    set_start_offset(3);
    send_process(4, 3, 1'b0);
    send_process(0, 7, 1'b0);
    send_process(20, 2, 1'b0);
    send_process(21, 5, 1'b0);
    send_process(22, 0, 1'b0);
    send_process(24, 1, 1'b0);
    send_process(30, 2, 1'b0);
    send_process(30, 2, 1'b1);
  endtask

  // Sixteen loads without the last flag: the full store must start the
  // schedule on its own. Run under the largest offset.
  task automatic test_full_store();
    set_start_offset(4095);
    for (int i = 0; i < SLOTS; i++) begin
      if (i == 0) begin
        send_process(0, 4095, 1'b0);
      end else if (i == SLOTS - 1) begin
        send_process(4095, 1, 1'b0);
      end else begin
        send_process($urandom_range(0, 4095), $urandom_range(1, 4095), 1'b0);
      end
    end
  endtask

  // Random sets. Most are small; arrivals and service lengths are drawn
  // from narrow spans (many ties and preemptions), wider spans or the whole range.
  // A set of sixteen sometimes leaves the last flag clear so that the full
  // store closes it. The offset moves every few sets.
  task automatic test_random_sets(input int unsigned budget);
    int unsigned sent;
    int unsigned set_size;
    int unsigned arrival_span;
    int unsigned service_span;
    int unsigned set_no;
    bit          closes;
    sent = 0;
    set_no = 0;
    while (sent < budget) begin
      if (set_no % 5 == 0) begin
        case ($urandom_range(0, 3))
          0:       set_start_offset(0);
          1:       set_start_offset(4095);
          default: set_start_offset($urandom_range(0, 4095));
        endcase
      end
      case ($urandom_range(0, 2))
        0:       in_gap_pct = 0;
        1:       in_gap_pct = 20;
        default: in_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       out_stall_pct = 0;
        1:       out_stall_pct = 20;
        default: out_stall_pct = 50;
      endcase
      set_size = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, SLOTS);
      case ($urandom_range(0, 2))
        0:       arrival_span = 15;
        1:       arrival_span = 300;
        default: arrival_span = 4095;
      endcase
      case ($urandom_range(0, 2))
        0:       service_span = 8;
        1:       service_span = 100;
        default: service_span = 4095;
      endcase
      for (int k = 0; k < set_size; k++) begin
        closes = (k == set_size - 1) && (set_size < SLOTS || $urandom_range(0, 1));
        send_process($urandom_range(0, arrival_span), $urandom_range(1, service_span),
                     closes);
      end
      sent += set_size;
      set_no++;
    end
  endtask

  // The closing stretch draws no random gaps or stalls on either side.
  task automatic test_steady_stream();
    wait_for_reports();
    calm = 1'b1;
    test_random_sets(40);
  endtask

  // Receiver: out_ready drops in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Every result transaction is matched against the oldest expectation.
  // The same process counts the cycles in which no transaction happens.
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got index %0d finish %0d",
                   $time, out_data.process_index, out_data.finish_time);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("process_index", want.process_index, out_data.process_index);
          check_field("finish_time", want.finish_time, out_data.finish_time);
          check_field("turnaround_time", want.turnaround_time, out_data.turnaround_time);
          check_field("wait_time", want.wait_time, out_data.wait_time);
          check_field("last_result", want.last_result, out_data.last_result);
          reports_checked++;
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sequence_main
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lone_processes();
    test_scheduling_rules();
    test_full_store();
    test_random_sets(200);
    test_steady_stream();

    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d processes in %0d schedules, %0d results compared,",
             loads_sent, sets_sent, reports_checked);
    $display("with %0d start_offset writes including both ends of its range.",
             offsets_written);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: shortest_remaining_time_scheduler.f
+incdir+hdl
hdl/srt_pkg.sv
hdl/srt_cell.sv
hdl/shortest_remaining_time_scheduler.sv
sim/tb_shortest_remaining_time_scheduler.sv
